// File: sv/nls_pkg.sv
// Shared types, character codes and reset values for the numeric literal scanner.
package nls_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int VALUE_W        = 63;
	localparam int CONSUMED_W     = 16;

	localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

	// Character codes used by the decoder
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF  = 8'h66;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_LB  = 8'h62;
	localparam logic [7:0] CH_UB  = 8'h42;
	localparam logic [7:0] CH_LO  = 8'h6f;
	localparam logic [7:0] CH_UO  = 8'h4f;
	localparam logic [7:0] CH_LX  = 8'h78;
	localparam logic [7:0] CH_UX  = 8'h58;
	localparam logic [7:0] CH_DOT = 8'h2e;

	typedef enum logic [2:0] {
		KIND_INVALID = 3'd0,
		KIND_BIN     = 3'd1,
		KIND_OCT     = 3'd2,
		KIND_DEC     = 3'd3,
		KIND_HEX     = 3'd4,
		KIND_FLT     = 3'd5
	} kind_t;

	typedef struct packed {
		logic       is_dec;   // '0'..'9'
		logic       is_hex;   // '0'..'9', 'a'..'f', 'A'..'F'
		logic [3:0] digit;    // digit value when is_hex
		logic       is_b;
		logic       is_o;
		logic       is_x;
		logic       is_dot;
	} char_class_t;

	typedef struct packed {
		kind_t              kind;
		logic               dot;
		logic               stopped;
		logic [VALUE_W-1:0] value;
		logic               clip;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		kind:    KIND_DEC,
		dot:     1'b0,
		stopped: 1'b0,
		value:   '0,
		clip:    1'b0
	};

endpackage

// File: sv/nls_classify.sv
// Character decoder: digit value and the prefix and dot marks of one character.
module nls_classify (
	input  logic [7:0]                ch,
	output nls_pkg::char_class_t      cls
);
	import nls_pkg::*;

	logic lower_hex;
	logic upper_hex;
	logic [7:0] lower_val;
	logic [7:0] upper_val;
	logic [7:0] dec_val;

	assign lower_hex = (ch >= CH_LA) && (ch <= CH_LF);
	assign upper_hex = (ch >= CH_UA) && (ch <= CH_UF);
	assign lower_val = ch - CH_LA + 8'd10;
	assign upper_val = ch - CH_UA + 8'd10;
	assign dec_val   = ch - CH_0;

	always_comb begin
		cls.is_dec = (ch >= CH_0) && (ch <= CH_9);
		cls.is_hex = cls.is_dec || lower_hex || upper_hex;
		priority if (lower_hex) begin
			cls.digit = lower_val[3:0];
		end else if (upper_hex) begin
			cls.digit = upper_val[3:0];
		end else begin
			cls.digit = dec_val[3:0];
		end
		cls.is_b   = (ch == CH_LB) || (ch == CH_UB);
		cls.is_o   = (ch == CH_LO) || (ch == CH_UO);
		cls.is_x   = (ch == CH_LX) || (ch == CH_UX);
		cls.is_dot = (ch == CH_DOT);
	end

endmodule

// File: sv/nls_scan.sv
// Next-state logic: one character step of the literal scanner, with saturating accumulate.
module nls_scan (
	input  nls_pkg::scan_state_t st,
	input  nls_pkg::char_class_t cls,
	input  logic                 first,
	input  logic                 second,
	input  logic                 last,
	output nls_pkg::scan_state_t nx
);
	import nls_pkg::*;

	logic [VALUE_W+3:0] v_ext;
	logic [VALUE_W+3:0] prod;
	logic [VALUE_W+3:0] sum;
	logic               fits;
	logic               ovf;

	assign v_ext = {4'b0000, st.value};

	// Scale by the radix of the current kind with shifts, plus one add for decimal
	always_comb begin
		unique case (st.kind)
			KIND_BIN: begin
				prod = v_ext << 1;
				fits = cls.is_dec && (cls.digit < 4'd2);
			end
			KIND_OCT: begin
				prod = v_ext << 3;
				fits = cls.is_dec && (cls.digit < 4'd8);
			end
			KIND_HEX: begin
				prod = v_ext << 4;
				fits = cls.is_hex;
			end
			KIND_DEC: begin
				prod = (v_ext << 3) + (v_ext << 1);
				fits = cls.is_dec;
			end
			default: begin
				prod = v_ext;
				fits = 1'b0;
			end
		endcase
	end

	assign sum = prod + (VALUE_W+4)'(cls.digit);
	assign ovf = st.clip || (sum[VALUE_W+3:VALUE_W] != 4'b0000);

	always_comb begin
		nx = st;
		if (!st.stopped) begin
			priority if (first) begin
				if (!cls.is_dec) begin
					nx.stopped = 1'b1;
				end else if (cls.digit == 4'd0) begin
					nx.kind = KIND_OCT;
				end else begin
					nx.kind  = KIND_DEC;
					nx.value = VALUE_W'(cls.digit);
				end
			end else if (second && (st.kind == KIND_OCT) &&
					(cls.is_b || cls.is_o || cls.is_x || cls.is_dot)) begin
				// Prefix letter needs a following character
				priority if (cls.is_b) begin
					nx.kind    = KIND_BIN;
					nx.stopped = last;
				end else if (cls.is_o) begin
					nx.kind    = KIND_OCT;
					nx.stopped = last;
				end else if (cls.is_x) begin
					nx.kind    = KIND_HEX;
					nx.stopped = last;
				end else begin
					nx.kind = KIND_FLT;
					nx.dot  = 1'b1;
				end
			end else if ((st.kind == KIND_DEC) && cls.is_dot && !st.dot) begin
				nx.kind = KIND_FLT;
				nx.dot  = 1'b1;
			end else if (st.kind == KIND_FLT) begin
				nx.stopped = !cls.is_dec;
			end else if (!fits) begin
				nx.stopped = 1'b1;
			end else if (ovf) begin
				nx.value = VALUE_MAX;
				nx.clip  = 1'b1;
			end else begin
				nx.value = sum[VALUE_W-1:0];
			end
		end
	end

endmodule

// File: sv/numeric_literal_scanner_core.sv
// Top level of the numeric literal scanner: input stage, scan state and result register.
//
// Usage: feed one character per beat on the input channel (in_valid/in_ready,
// payload ch and last); last marks the final character of a literal. Each
// literal yields exactly one result beat on the output channel
// (out_valid/out_ready, payload kind, consumed, value, saturated); beats with
// last low yield nothing.
// Path: a character accepted on the input channel is registered in the input
// stage and scanned from there; for a final character the result register loads.
// Throughput: one character per cycle unless a final character waits for the
// result register; one combinational scan step feeds the state and result registers.
// Stall: while a result waits for out_ready, non-final characters of the next
// literal keep flowing; a final character holds in the input register until
// the result register frees, and in_ready drops behind it.
// Reset: arst_n clears the input stage, the result valid and the scan state
// (kind decimal, count zero, accumulator zero); the block is ready at once.
// After each result the scan state returns to the same reset values.
module numeric_literal_scanner_core #(
	parameter int COUNT_BITS = nls_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         ch,
	input  logic                               last,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         kind,
	output logic [nls_pkg::CONSUMED_W-1:0]     consumed,
	output logic [nls_pkg::VALUE_W-1:0]        value,
	output logic                               saturated
);
	import nls_pkg::*;

	// Input stage
	logic              valid_s1;
	logic [7:0]        ch_s1;
	logic              last_s1;

	// Scan state
	scan_state_t           st_q;
	scan_state_t           st_nx;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [31:0]           cnt_wide;

	// Result register
	logic                  out_valid_q;
	kind_t                 kind_q;
	logic [CONSUMED_W-1:0] consumed_q;
	logic [VALUE_W-1:0]    value_q;
	logic                  sat_q;

	char_class_t cls;
	logic        adv;
	logic        out_free;

	// Advance the input stage unless a final beat finds the result register busy
	assign out_free = !out_valid_q || out_ready;
	assign adv      = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || adv;

	nls_classify u_classify (
		.ch  (ch_s1),
		.cls (cls)
	);

	nls_scan u_scan (
		.st     (st_q),
		.cls    (cls),
		.first  (cnt_q == '0),
		.second (cnt_q == COUNT_BITS'(1)),
		.last   (last_s1),
		.nx     (st_nx)
	);

	// Saturating length count, then clip the report to the port width
	assign cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);
	assign cnt_wide = 32'(cnt_inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	// Step the scan state; drop back to reset after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= SCAN_RESET;
			cnt_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				st_q  <= SCAN_RESET;
				cnt_q <= '0;
			end else begin
				st_q  <= st_nx;
				cnt_q <= cnt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			if (st_nx.stopped) begin
				kind_q     <= KIND_INVALID;
				consumed_q <= '0;
				value_q    <= '0;
				sat_q      <= 1'b0;
			end else begin
				kind_q     <= st_nx.kind;
				consumed_q <= (cnt_wide > 32'h0000_FFFF) ? '1 : cnt_wide[CONSUMED_W-1:0];
				if (st_nx.kind == KIND_FLT) begin
					value_q <= '0;
					sat_q   <= 1'b0;
				end else begin
					value_q <= st_nx.value;
					sat_q   <= st_nx.clip;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign consumed  = consumed_q;
	assign value     = value_q;
	assign saturated = sat_q;

`ifndef SYNTHESIS
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_INVALID) |-> (consumed == '0) && (value == '0) && !saturated)
		else $error("invalid result carries nonzero payload");

	a_valid_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_INVALID) |-> (consumed != '0))
		else $error("valid result with zero length");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (value == VALUE_MAX) && (kind != KIND_FLT))
		else $error("saturated result without clipped value");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> (cnt_q == '0) && !st_q.stopped && (st_q.value == '0))
		else $error("scan state not cleared after final beat");
`endif

endmodule

// File: tb/nls_result_checker.sv
// Beat monitor for the numeric literal scanner: predicts each literal's result and compares.
module nls_result_checker #(
	parameter int COUNT_BITS = nls_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [7:0]                     ch,
	input  logic                           last,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [2:0]                     kind,
	input  logic [nls_pkg::CONSUMED_W-1:0] consumed,
	input  logic [nls_pkg::VALUE_W-1:0]    value,
	input  logic                           saturated,
	output int                             mismatch_count,
	output int                             results_owed
);
	import nls_pkg::*;

	typedef struct packed {
		logic [2:0]            kind;
		logic [CONSUMED_W-1:0] consumed;
		logic [VALUE_W-1:0]    value;
		logic                  saturated;
	} literal_result_t;

	literal_result_t scan_results_q[$];

	// Predicted scan state of the literal in flight
	kind_t                 lit_kind;
	logic [COUNT_BITS-1:0] lit_len;
	logic                  lit_dot;
	logic                  lit_dead;
	logic [VALUE_W-1:0]    lit_acc;
	logic                  lit_clip;

	function automatic void clear_literal();
		lit_kind = KIND_DEC;
		lit_len  = '0;
		lit_dot  = 1'b0;
		lit_dead = 1'b0;
		lit_acc  = '0;
		lit_clip = 1'b0;
	endfunction

	function automatic int digit_value(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9)
			return int'(c - CH_0);
		if (c >= CH_LA && c <= CH_LF)
			return int'(c - CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UF)
			return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	// Fold one digit into the accumulator, clipping at the signed 64-bit maximum
	function automatic void add_digit(input logic [7:0] c, input int radix);
		int d;
		logic [63:0] lim;
		logic [63:0] next;
		d = digit_value(c);
		if (d < 0 || d >= radix) begin
			lit_dead = 1'b1;
		end else begin
			lim = ({1'b0, VALUE_MAX} - 64'(d)) / 64'(radix);
			if (lit_clip || {1'b0, lit_acc} > lim) begin
				lit_acc  = VALUE_MAX;
				lit_clip = 1'b1;
			end else begin
				next    = {1'b0, lit_acc} * 64'(radix) + 64'(d);
				lit_acc = next[VALUE_W-1:0];
			end
		end
	endfunction

	function automatic void scan_literal_char(input logic [7:0] c, input logic is_last);
		if (lit_len == '0) begin
			if (c < CH_0 || c > CH_9)
				lit_dead = 1'b1;
			else if (c == CH_0)
				lit_kind = KIND_OCT;
			else begin
				lit_kind = KIND_DEC;
				lit_acc  = VALUE_W'(c - CH_0);
			end
		end else if (lit_len == 1 && lit_kind == KIND_OCT) begin
			// a prefix letter counts only when a character follows it
			if (c == CH_LB || c == CH_UB) begin
				lit_kind = KIND_BIN;
				if (is_last)
					lit_dead = 1'b1;
			end else if (c == CH_LO || c == CH_UO) begin
				if (is_last)
					lit_dead = 1'b1;
			end else if (c == CH_LX || c == CH_UX) begin
				lit_kind = KIND_HEX;
				if (is_last)
					lit_dead = 1'b1;
			end else if (c == CH_DOT) begin
				lit_kind = KIND_FLT;
				lit_dot  = 1'b1;
			end else
				add_digit(c, 8);
		end else begin
			case (lit_kind)
				KIND_BIN: add_digit(c, 2);
				KIND_OCT: add_digit(c, 8);
				KIND_HEX: add_digit(c, 16);
				KIND_DEC: begin
					if (c == CH_DOT && !lit_dot) begin
						lit_kind = KIND_FLT;
						lit_dot  = 1'b1;
					end else
						add_digit(c, 10);
				end
				KIND_FLT: begin
					if (c < CH_0 || c > CH_9)
						lit_dead = 1'b1;
				end
				default: lit_dead = 1'b1;
			endcase
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_beats
		literal_result_t want;
		int              fails;
		if (!arst_n) begin
			clear_literal();
			scan_results_q.delete();
			mismatch_count <= 0;
			results_owed   <= 0;
		end else begin
			fails = 0;
			if (out_valid && out_ready) begin
				if (scan_results_q.size() == 0) begin
					$display("%0t: result beat with none expected, got kind=%0d consumed=%0d value=%h saturated=%b",
						$time, kind, consumed, value, saturated);
					fails++;
				end else begin
					want = scan_results_q.pop_front();
					if (kind != want.kind || consumed != want.consumed ||
						value != want.value || saturated != want.saturated) begin
						$display("%0t: mismatch, expected kind=%0d consumed=%0d value=%h saturated=%b",
							$time, want.kind, want.consumed, want.value, want.saturated);
						$display("%0t:           got kind=%0d consumed=%0d value=%h saturated=%b",
							$time, kind, consumed, value, saturated);
						fails++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (!lit_dead)
					scan_literal_char(ch, last);
				if (lit_len != '1)
					lit_len = lit_len + 1'b1;
				if (last) begin
					if (lit_dead) begin
						want = '0;
						want.kind = KIND_INVALID;
					end else begin
						want.kind = lit_kind;
						want.consumed = (32'(lit_len) > 32'hFFFF) ? 16'hFFFF : 16'(lit_len);
						want.value = (lit_kind == KIND_FLT) ? '0 : lit_acc;
						want.saturated = (lit_kind == KIND_FLT) ? 1'b0 : lit_clip;
					end
					scan_results_q.push_back(want);
					clear_literal();
				end
			end
			mismatch_count <= mismatch_count + fails;
			results_owed   <= scan_results_q.size();
		end
	end

endmodule

// File: tb/tb_numeric_literal_scanner_core.sv
// Testbench top for numeric_literal_scanner_core: literal stimulus, output pacing and verdict.
module tb_numeric_literal_scanner_core;
	import nls_pkg::*;

	// Longest stretch without any beat: the receiver hold-off plus ample margin
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_CHARS = 245;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [7:0]            ch        = 8'h00;
	logic                  last      = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [2:0]            kind;
	logic [CONSUMED_W-1:0] consumed;
	logic [VALUE_W-1:0]    value;
	logic                  saturated;

	int   mismatch_count;
	int   results_owed;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic hold_req       = 1'b0;
	int   hold_left      = 0;
	int   quiet_cycles   = 0;

	// Characters of the literal being built, sent front to back
	logic [7:0] lit_chars_q[$];

	numeric_literal_scanner_core #(
		.COUNT_BITS(COUNT_BITS_DEF)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.consumed  (consumed),
		.value     (value),
		.saturated (saturated)
	);

	nls_result_checker #(
		.COUNT_BITS(COUNT_BITS_DEF)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.ch             (ch),
		.last           (last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.consumed       (consumed),
		.value          (value),
		.saturated      (saturated),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random stalls at the phase rate, or a long hold-off on request.
	// The hold-off lets the sender keep offering so that a final character backs
	// up behind the full result register and in_ready drops.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  <= 1'b0;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Count cycles in which no beat moves on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("numeric_literal_scanner_core regression: fail");
		$finish;
	end

	// Offer one character beat; idle first at the phase rate, then hold the
	// payload until the beat is taken.
	task automatic send_char(input logic [7:0] c, input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch       <= c;
		last     <= is_last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Send the built literal, flagging its final character, and drop it
	task automatic send_literal();
		for (int i = 0; i < lit_chars_q.size(); i++)
			send_char(lit_chars_q[i], i == lit_chars_q.size() - 1);
		lit_chars_q.delete();
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			lit_chars_q.push_back(s[i]);
		send_literal();
	endtask

	function automatic logic [7:0] pick_digit(input int radix);
		int d;
		d = $urandom_range(radix - 1);
		if (d < 10)
			return CH_0 + 8'(d);
		return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(d - 10);
	endfunction

	function automatic logic [7:0] pick_prefix();
		case ($urandom_range(5))
			0: return CH_LB;
			1: return CH_UB;
			2: return CH_LO;
			3: return CH_UO;
			4: return CH_LX;
			default: return CH_UX;
		endcase
	endfunction

	// Mostly short digit runs; now and then long enough to clip the value
	function automatic int pick_len();
		return ($urandom_range(9) == 0) ? $urandom_range(70, 16) : $urandom_range(8, 1);
	endfunction

	function automatic void push_digits(input int radix, input int n);
		repeat (n)
			lit_chars_q.push_back(pick_digit(radix));
	endfunction

	// Build one literal: three quarters well formed with random digits, the
	// rest random bytes, bare prefixes, a second dot or a corrupted character.
	function automatic void build_literal();
		int pick;
		int n;
		int pos;
		pick = $urandom_range(99);
		n    = pick_len();
		if (pick < 12) begin
			lit_chars_q.push_back(CH_0);
			lit_chars_q.push_back($urandom_range(1) ? CH_LB : CH_UB);
			push_digits(2, n);
		end else if (pick < 22) begin
			lit_chars_q.push_back(CH_0);
			lit_chars_q.push_back($urandom_range(1) ? CH_LO : CH_UO);
			push_digits(8, n);
		end else if (pick < 32) begin
			// leading zero octal, a lone zero when n is one
			lit_chars_q.push_back(CH_0);
			push_digits(8, n - 1);
		end else if (pick < 47) begin
			lit_chars_q.push_back(CH_0 + 8'($urandom_range(9, 1)));
			push_digits(10, n - 1);
		end else if (pick < 62) begin
			lit_chars_q.push_back(CH_0);
			lit_chars_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
			push_digits(16, n);
		end else if (pick < 76) begin
			if ($urandom_range(1))
				lit_chars_q.push_back(CH_0);
			else begin
				lit_chars_q.push_back(CH_0 + 8'($urandom_range(9, 1)));
				push_digits(10, $urandom_range(3));
			end
			lit_chars_q.push_back(CH_DOT);
			push_digits(10, $urandom_range(4));
		end else if (pick < 88) begin
			repeat ($urandom_range(6, 1))
				lit_chars_q.push_back(8'($urandom_range(255)));
		end else if (pick < 92) begin
			lit_chars_q.push_back(CH_0);
			lit_chars_q.push_back(pick_prefix());
		end else if (pick < 95) begin
			lit_chars_q.push_back(CH_0 + 8'($urandom_range(9, 1)));
			lit_chars_q.push_back(CH_DOT);
			push_digits(10, $urandom_range(2));
			lit_chars_q.push_back(CH_DOT);
			push_digits(10, $urandom_range(2));
		end else begin
			lit_chars_q.push_back(CH_0 + 8'($urandom_range(9, 1)));
			push_digits(10, n);
			pos = $urandom_range(lit_chars_q.size() - 1);
			lit_chars_q[pos] = 8'($urandom_range(255));
		end
	endfunction

	initial begin : stimulus
		int sent;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed literals: every kind, bad first characters, bare prefixes,
		// digits outside the radix, a second dot, characters after the stop,
		// and the value limit on both sides.
		send_text("0");
		send_text("9");
		send_text("0b1");
		send_text("0B0");
		send_text("0o7");
		send_text("0O17");
		send_text("017");
		send_text("08");
		send_text("123");
		send_text("0x1f");
		send_text("0XaF");
		send_text("3.14");
		send_text("0.");
		send_text("1.2.3");
		send_text("0b");
		send_text("0x");
		send_text("a1");
		send_text("0b12");
		send_text("0x1g23");
		send_text("9223372036854775807");
		send_text("9223372036854775808");
		send_text("0xFFFFFFFFFFFFFFFF");
		// zero byte alone and after a digit, and the top character code
		send_char(8'h00, 1'b1);
		send_char(CH_0 + 8'd1, 1'b0);
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);

		// Random phases: no idling with one long hold-off, sender idle,
		// receiver stalling, both idling.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					hold_req       <= 1'b1;
				end
				1: begin
					send_idle_pct  = 61;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 61;
				end
				default: begin
					send_idle_pct  = 38;
					recv_stall_pct = 38;
				end
			endcase
			sent = 0;
			while (sent < PHASE_CHARS) begin
				build_literal();
				sent += lit_chars_q.size();
				send_literal();
			end
		end
		in_valid <= 1'b0;

		// Drain: let the checker see the final beat, wait for every result,
		// then wait on to catch any stray beat.
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("numeric_literal_scanner_core regression: pass");
		else
			$display("numeric_literal_scanner_core regression: fail");
		$finish;
	end

endmodule
